// ===== hw/rtl/angle_pid_integral_reset_assert.svh =====
// Assertion macros shared by the angle PID checker.
`ifndef ANGLE_PID_INTEGRAL_RESET_ASSERT_SVH
`define ANGLE_PID_INTEGRAL_RESET_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define APIR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition in one cycle implies the consequent in the next cycle.
`define APIR_ASSERT_NEXT(label, cond, consequent, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (consequent)) \
      else $error(msg);

`endif

// ===== hw/rtl/apir_pkg.sv =====
// Types and constants for the angle PID controller with integral reset.
package apir_pkg;

   localparam int GAIN_WIDTH     = 16;
   localparam int GAIN_FRAC      = 8;
   localparam int LIMIT_WIDTH    = 23;
   localparam int DRIVE_WIDTH    = 32;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_INDEX_LSB  = 2;
   localparam int CSR_INDEX_BITS = CSR_ADDR_WIDTH - CSR_INDEX_LSB;
   localparam int LIMIT_DEGREES  = 7000;
   localparam int THRESH_DEGREES = 360;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_GAIN_P          = 3'd0,
      REG_GAIN_I          = 3'd1,
      REG_GAIN_D          = 3'd2,
      REG_INTEGRAL_LIMIT  = 3'd3,
      REG_RESET_THRESHOLD = 3'd4
   } csr_index_type;

endpackage

// ===== hw/rtl/angle_pid_integral_reset.sv =====
// Angle PID controller: request error in, saturated drive out, CSR-programmed gains.
// A request accept loads the input register; the result register drives rsp_tvalid.
// Throughput: one request per cycle unless rsp stalls; the integral add, three gain
// multiplies and the clamp sit in the single stage between the two registers.
// Reset: synchronous active-high; clears gains, integral and previous error, and
// loads integral_limit = 7000 and reset_threshold = 360 degrees in the error format.
module angle_pid_integral_reset #(
   parameter int ERROR_WIDTH    = 24,
   parameter int FRACTION_BITS  = 8,
   localparam int REQ_DATA_WIDTH = ((ERROR_WIDTH + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [REQ_DATA_WIDTH-1:0]           req_tdata,  // angle_error
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [apir_pkg::DRIVE_WIDTH-1:0]    rsp_tdata,  // drive
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [apir_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [apir_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [apir_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);
   import apir_pkg::*;

   localparam int INTEG_WIDTH = ((ERROR_WIDTH > 24) ? ERROR_WIDTH : 24) + 2;
   localparam int PROD_WIDTH  = GAIN_WIDTH + INTEG_WIDTH;
   localparam int SUM_WIDTH   = PROD_WIDTH + 2;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET =
      LIMIT_WIDTH'(LIMIT_DEGREES * (2 ** FRACTION_BITS));
   localparam logic [LIMIT_WIDTH-1:0] THRESH_RESET =
      LIMIT_WIDTH'(THRESH_DEGREES * (2 ** FRACTION_BITS));

   logic signed [GAIN_WIDTH-1:0]  gain_p_ff, gain_i_ff, gain_d_ff;
   logic        [LIMIT_WIDTH-1:0] limit_ff, thresh_ff;

   logic                          in_valid_ff;
   logic signed [ERROR_WIDTH-1:0] err_ff;
   logic                          rsp_valid_ff;
   logic [DRIVE_WIDTH-1:0]        drive_ff;
   logic signed [INTEG_WIDTH-1:0] integral_ff;
   logic signed [ERROR_WIDTH-1:0] prev_err_ff;

   logic                          csr_write;
   csr_index_type                 csr_index;
   logic                          out_free;
   logic                          advance;
   logic                          req_fire;

   logic signed [INTEG_WIDTH-1:0] err_ext, prev_ext, thresh_ext, limit_ext;
   logic signed [INTEG_WIDTH-1:0] integral_pre, err_delta, integral_in;
   logic                          reset_hit;
   logic signed [PROD_WIDTH-1:0]  prod_p, prod_i, prod_d;
   logic signed [SUM_WIDTH-1:0]   acc_sum, acc_shift;
   logic [SUM_WIDTH-DRIVE_WIDTH:0] acc_upper;
   logic [DRIVE_WIDTH-1:0]        drive_in;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_WIDTH-1:CSR_INDEX_LSB]);

   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         REG_GAIN_P:          csr_prdata = CSR_DATA_WIDTH'(unsigned'(gain_p_ff));
         REG_GAIN_I:          csr_prdata = CSR_DATA_WIDTH'(unsigned'(gain_i_ff));
         REG_GAIN_D:          csr_prdata = CSR_DATA_WIDTH'(unsigned'(gain_d_ff));
         REG_INTEGRAL_LIMIT:  csr_prdata = CSR_DATA_WIDTH'(limit_ff);
         REG_RESET_THRESHOLD: csr_prdata = CSR_DATA_WIDTH'(thresh_ff);
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff <= '0;
         gain_i_ff <= '0;
         gain_d_ff <= '0;
         limit_ff  <= LIMIT_RESET;
         thresh_ff <= THRESH_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_GAIN_P:          gain_p_ff <= signed'(csr_pwdata[GAIN_WIDTH-1:0]);
            REG_GAIN_I:          gain_i_ff <= signed'(csr_pwdata[GAIN_WIDTH-1:0]);
            REG_GAIN_D:          gain_d_ff <= signed'(csr_pwdata[GAIN_WIDTH-1:0]);
            REG_INTEGRAL_LIMIT:  limit_ff  <= csr_pwdata[LIMIT_WIDTH-1:0];
            REG_RESET_THRESHOLD: thresh_ff <= csr_pwdata[LIMIT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // handshake
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign advance    = in_valid_ff & out_free;
   assign req_tready = ~in_valid_ff | out_free;
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = drive_ff;

   // datapath
   assign err_ext    = INTEG_WIDTH'(err_ff);
   assign prev_ext   = INTEG_WIDTH'(prev_err_ff);
   assign thresh_ext = INTEG_WIDTH'(signed'({1'b0, thresh_ff}));
   assign limit_ext  = INTEG_WIDTH'(signed'({1'b0, limit_ff}));

   assign reset_hit    = err_ext > thresh_ext;
   assign integral_pre = reset_hit ? '0 : integral_ff + err_ext;
   assign err_delta    = err_ext - prev_ext;

   assign prod_p = PROD_WIDTH'(gain_p_ff) * PROD_WIDTH'(err_ext);
   assign prod_i = PROD_WIDTH'(gain_i_ff) * PROD_WIDTH'(integral_pre);
   assign prod_d = PROD_WIDTH'(gain_d_ff) * PROD_WIDTH'(err_delta);

   assign acc_sum   = SUM_WIDTH'(prod_p) + SUM_WIDTH'(prod_i) + SUM_WIDTH'(prod_d);
   assign acc_shift = acc_sum >>> GAIN_FRAC;
   assign acc_upper = acc_shift[SUM_WIDTH-1:DRIVE_WIDTH-1];

   always_comb begin
      if ((&acc_upper) | ~(|acc_upper)) begin
         drive_in = acc_shift[DRIVE_WIDTH-1:0];
      end else if (acc_shift[SUM_WIDTH-1]) begin
         drive_in = {1'b1, {(DRIVE_WIDTH-1){1'b0}}};
      end else begin
         drive_in = {1'b0, {(DRIVE_WIDTH-1){1'b1}}};
      end
   end

   always_comb begin
      priority if (integral_pre > limit_ext) begin
         integral_in = limit_ext;
      end else if (integral_pre < -limit_ext) begin
         integral_in = -limit_ext;
      end else begin
         integral_in = integral_pre;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         integral_ff  <= '0;
         prev_err_ff  <= '0;
      end else begin
         if (req_fire) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            integral_ff  <= integral_in;
            prev_err_ff  <= err_ff;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         err_ff <= signed'(req_tdata[ERROR_WIDTH-1:0]);
      end
      if (advance) begin
         drive_ff <= drive_in;
      end
   end

endmodule

// ===== hw/rtl/apir_check.sv =====
// Port-level checker for the angle PID controller, bound to the top level.
`include "angle_pid_integral_reset_assert.svh"

module apir_check #(
   parameter int ERROR_WIDTH = 24,
   localparam int REQ_DATA_WIDTH = ((ERROR_WIDTH + 7) / 8) * 8
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [REQ_DATA_WIDTH-1:0]           req_tdata,  // angle_error
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [apir_pkg::DRIVE_WIDTH-1:0]    rsp_tdata,  // drive
   input logic                                csr_pready
);
   import apir_pkg::*;

   logic req_fire;
   logic req_stall;
   logic rsp_stall;

   assign req_fire  = req_tvalid & req_tready;
   assign req_stall = req_tvalid & ~req_tready;
   assign rsp_stall = rsp_tvalid & ~rsp_tready;

   `APIR_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_tdata), "stalled drive changed")
   `APIR_ASSERT_NEXT(a_req_hold, req_stall, req_tvalid && $stable(req_tdata), "waiting request changed")
   `APIR_ASSERT(a_pready_high, csr_pready, "csr_pready dropped")
   `APIR_ASSERT(a_empty_ready, !rsp_tvalid |-> req_tready, "request refused with empty output")
   `APIR_ASSERT(a_rsp_source, $rose(rsp_tvalid) |-> $past(req_fire, 2), "drive without request")

endmodule

bind angle_pid_integral_reset apir_check #(.ERROR_WIDTH(ERROR_WIDTH)) u_apir_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the angle PID controller with one-sided integral reset.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import apir_pkg::*;

   localparam int ERROR_WIDTH = 24;
   localparam int REQ_DATA_WIDTH = ((ERROR_WIDTH + 7) / 8) * 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_REQUESTS = 63;
   localparam logic [ERROR_WIDTH-1:0] ERROR_MAX = {1'b0, {(ERROR_WIDTH-1){1'b1}}};
   localparam logic [ERROR_WIDTH-1:0] ERROR_MIN = {1'b1, {(ERROR_WIDTH-1){1'b0}}};
   localparam logic [LIMIT_WIDTH-1:0] BOUND_MAX = '1;
   localparam logic [GAIN_WIDTH-1:0] GAIN_MAX = {1'b0, {(GAIN_WIDTH-1){1'b1}}};
   localparam logic [GAIN_WIDTH-1:0] GAIN_MIN = {1'b1, {(GAIN_WIDTH-1){1'b0}}};
   localparam longint DRIVE_MAX = (longint'(1) << (DRIVE_WIDTH - 1)) - 1;
   localparam longint DRIVE_MIN = -(longint'(1) << (DRIVE_WIDTH - 1));

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata;  // angle_error
   logic rsp_tvalid;
   logic rsp_tready;
   logic [DRIVE_WIDTH-1:0] rsp_tdata;     // drive
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic csr_pready;

   // controller state as predicted by the testbench
   longint p_gain;
   longint i_gain;
   longint d_gain;
   longint clamp_limit;
   longint zero_threshold;
   longint integral_acc;
   longint last_error;

   logic [DRIVE_WIDTH-1:0] drive_expected[$];
   int error_count;
   int idle_cycles;
   int rsp_wait;
   bit steady;

   angle_pid_integral_reset #(
      .ERROR_WIDTH(ERROR_WIDTH),
      .FRACTION_BITS(8)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic void predict_drive(input logic [ERROR_WIDTH-1:0] raw);
      longint err;
      longint acc;
      longint drv;
      err = longint'($signed(raw));
      if (err > zero_threshold) integral_acc = 0;
      else integral_acc += err;
      acc = p_gain * err + i_gain * integral_acc + d_gain * (err - last_error);
      drv = acc >>> GAIN_FRAC;
      if (drv > DRIVE_MAX) drv = DRIVE_MAX;
      if (drv < DRIVE_MIN) drv = DRIVE_MIN;
      if (integral_acc > clamp_limit) integral_acc = clamp_limit;
      else if (integral_acc < -clamp_limit) integral_acc = -clamp_limit;
      last_error = err;
      drive_expected.push_back(drv[DRIVE_WIDTH-1:0]);
   endfunction

   task automatic check_drive(input logic [DRIVE_WIDTH-1:0] got);
      logic [DRIVE_WIDTH-1:0] want;
      if (drive_expected.size() == 0) begin
         report_mismatch($sformatf("unexpected drive %0d", $signed(got)));
      end else begin
         want = drive_expected.pop_front();
         if (got !== want)
            report_mismatch($sformatf("drive %0d, expected %0d", $signed(got), $signed(want)));
      end
   endtask

   // result side: check every accepted drive, stall at random outside the steady phase
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_drive(rsp_tdata);
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!steady) rsp_wait = idle_length();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic program_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                              input logic [CSR_DATA_WIDTH-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_WIDTH'(idx) << CSR_INDEX_LSB;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (csr_index_type'(idx))
         REG_GAIN_P: p_gain = longint'($signed(value[GAIN_WIDTH-1:0]));
         REG_GAIN_I: i_gain = longint'($signed(value[GAIN_WIDTH-1:0]));
         REG_GAIN_D: d_gain = longint'($signed(value[GAIN_WIDTH-1:0]));
         REG_INTEGRAL_LIMIT: clamp_limit = longint'(value[LIMIT_WIDTH-1:0]);
         REG_RESET_THRESHOLD: zero_threshold = longint'(value[LIMIT_WIDTH-1:0]);
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic program_gains(input logic [CSR_DATA_WIDTH-1:0] p, input logic [CSR_DATA_WIDTH-1:0] i,
                                input logic [CSR_DATA_WIDTH-1:0] d);
      program_reg(REG_GAIN_P, p);
      program_reg(REG_GAIN_I, i);
      program_reg(REG_GAIN_D, d);
   endtask

   task automatic send_error(input logic [ERROR_WIDTH-1:0] value);
      int gap;
      gap = steady ? 0 : idle_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_DATA_WIDTH'(value);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_drive(value);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (drive_expected.size() != 0) @(posedge clock);
   endtask

   task automatic test_reset_defaults();
      send_error('0);
      send_error(ERROR_MAX);
      send_error(ERROR_MIN);
      send_error(ERROR_WIDTH'(THRESH_DEGREES << 8));
      wait_idle();
   endtask

   task automatic test_extremes();
      program_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX);
      program_reg(REG_RESET_THRESHOLD, BOUND_MAX);
      program_reg(REG_INTEGRAL_LIMIT, BOUND_MAX);
      send_error(ERROR_MIN);
      send_error(ERROR_MAX);
      send_error(ERROR_MAX);
      wait_idle();
      program_gains(GAIN_MIN, GAIN_MIN, GAIN_MIN);
      send_error(ERROR_MAX);
      send_error(ERROR_MIN);
      wait_idle();
      // floor rounding of the gain scaling
      program_gains(1, 0, 0);
      send_error('1);
      send_error(ERROR_WIDTH'(255));
      send_error(ERROR_WIDTH'(-257));
      wait_idle();
   endtask

   task automatic test_one_sided_reset();
      program_gains(0, 256, 0);
      program_reg(REG_RESET_THRESHOLD, 1000);
      program_reg(REG_INTEGRAL_LIMIT, 5000);
      send_error(ERROR_WIDTH'(-3000));
      send_error(ERROR_WIDTH'(-3000));
      send_error(ERROR_WIDTH'(1000));
      send_error(ERROR_WIDTH'(1001));
      send_error(ERROR_MIN);
      send_error(ERROR_WIDTH'(2000));
      wait_idle();
   endtask

   task automatic test_integral_clamp();
      program_reg(REG_INTEGRAL_LIMIT, 0);
      send_error(ERROR_WIDTH'(500));
      send_error(ERROR_WIDTH'(-500));
      wait_idle();
      program_reg(REG_INTEGRAL_LIMIT, 300);
      send_error(ERROR_WIDTH'(700));
      send_error(ERROR_WIDTH'(700));
      send_error(ERROR_WIDTH'(-900));
      wait_idle();
   endtask

   task automatic test_register_masking();
      program_gains(32'hFFFF_0100, 32'h1234_FF00, 32'h8000_0080);
      program_reg(REG_INTEGRAL_LIMIT, 32'hFF80_0064);
      program_reg(REG_RESET_THRESHOLD, 32'hFF80_0200);
      for (int k = int'(REG_RESET_THRESHOLD) + 1; k < (1 << CSR_INDEX_BITS); k++)
         program_reg(CSR_INDEX_BITS'(k), $urandom());
      send_error(ERROR_WIDTH'(600));
      send_error(ERROR_WIDTH'(-150));
      wait_idle();
   endtask

   function automatic logic [CSR_DATA_WIDTH-1:0] pick_gain();
      logic [CSR_DATA_WIDTH-1:0] value;
      value = $urandom();
      case ($urandom_range(0, 9))
         0: value[GAIN_WIDTH-1:0] = GAIN_MIN;
         1: value[GAIN_WIDTH-1:0] = GAIN_MAX;
         2: value[GAIN_WIDTH-1:0] = '0;
         3, 4, 5: value[GAIN_WIDTH-1:0] = GAIN_WIDTH'(int'($urandom_range(0, 1023)) - 512);
         default: ;
      endcase
      return value;
   endfunction

   function automatic logic [CSR_DATA_WIDTH-1:0] pick_bound();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return CSR_DATA_WIDTH'(BOUND_MAX);
         2: return $urandom_range(0, 4095);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [ERROR_WIDTH-1:0] pick_error();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return ERROR_WIDTH'($urandom());
      if (r < 55) return ERROR_WIDTH'(zero_threshold + longint'(int'($urandom_range(0, 4)) - 2));
      if (r < 75) return ERROR_WIDTH'(int'($urandom_range(0, 8191)) - 4096);
      if (r < 85) begin
         case ($urandom_range(0, 4))
            0: return ERROR_MIN;
            1: return ERROR_MAX;
            2: return '0;
            3: return '1;
            default: return ERROR_WIDTH'(1);
         endcase
      end
      // large negative errors drive the integral into its clamp
      return ERROR_WIDTH'(-int'($urandom_range(0, 1 << 22)));
   endfunction

   task automatic test_random_operation();
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         program_gains(pick_gain(), pick_gain(), pick_gain());
         program_reg(REG_INTEGRAL_LIMIT, pick_bound());
         program_reg(REG_RESET_THRESHOLD, pick_bound());
         program_reg(CSR_INDEX_BITS'(int'(REG_RESET_THRESHOLD) + 1), $urandom());
         steady = (phase == 3);
         for (int n = 0; n < PHASE_REQUESTS; n++)
            send_error(pick_error());
         wait_idle();
         steady = 1'b0;
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      error_count = 0;
      idle_cycles = 0;
      rsp_wait = 0;
      steady = 1'b0;
      p_gain = 0;
      i_gain = 0;
      d_gain = 0;
      clamp_limit = longint'(LIMIT_DEGREES) << 8;
      zero_threshold = longint'(THRESH_DEGREES) << 8;
      integral_acc = 0;
      last_error = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_extremes();
      test_one_sided_reset();
      test_integral_clamp();
      test_register_masking();
      test_random_operation();

      wait_idle();
      repeat (6) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
